### rtl/adq_pkg.sv
// shared constants, codes and state type for the alarm deadline queue
package adq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_WIDTH_DEF   = 16;
  localparam int TIME_W          = 32;
  localparam int DELAY_W         = 16;
  localparam int IN_TAG_W        = 16;
  localparam int OUT_TAG_W       = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int NUM_W           = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ADD     = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_TICK_RD,
    ST_TICK_CMP
  } adq_state_t;

endpackage

### rtl/adq_entry_ram.sv
// entry store: one write port, one read port with registered read data
module adq_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/alarm_deadline_queue.sv
// top level: sorted alarm queue with a seconds counter
//
// usage
//   command channel: an item is taken at a clock edge with start high and busy
//   low. cmd selects a one-second tick or an add of an alarm (delay_seconds,
//   alarm_tag). results come out on kind/status/fired_tag/last, each shown for
//   exactly one cycle with valid high; the receiver cannot hold them off
//   an add answers with one acknowledgement: status full and no change when
//   the queue is full, shown the cycle after the item with busy never raised;
//   otherwise busy stays high while each queued alarm with a later deadline
//   than the new one is moved up one slot through the single entry memory
//   port; the ack shows as busy drops
//   a tick advances time (saturating) and reports every alarm now due, oldest
//   deadline first, at most MAX_RESULTS per tick, last set on the final one;
//   busy stays high while the due alarms are popped, until the queue empties,
//   the limit is hit or the head is not yet due; the final report shows as
//   busy drops. a quiet tick gives no result
//   reset (rst, synchronous) clears time, the entry count and the sequencer;
//   the entry memory is not cleared, only live slots are ever read
module alarm_deadline_queue
  import adq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [DELAY_W-1:0]   delay_seconds,
  input  logic [IN_TAG_W-1:0]  alarm_tag,
  output logic                 valid,
  output logic                 kind,
  output logic                 status,
  output logic [OUT_TAG_W-1:0] fired_tag,
  output logic                 last
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = TIME_W + TAG_WIDTH;

  // circular buffer: logical slot j lives at (head + j) mod depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  adq_state_t state, state_next;

  logic [TIME_W-1:0]    now_seconds, now_next;
  logic [TIME_W-1:0]    deadline, deadline_next;  // deadline of the alarm being added
  logic [TAG_WIDTH-1:0] new_tag, new_tag_next;
  logic [IDX_W-1:0]     slot, slot_next;          // logical slot under work
  logic [IDX_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     entry_count, count_next;
  logic [NUM_W-1:0]     num_fired, num_next;

  // fired alarm held back until we know whether another one follows
  logic                 pend_valid, pend_valid_next;
  logic [TAG_WIDTH-1:0] pend_tag, pend_tag_next;

  logic                 valid_next, kind_next, status_next, last_next;
  logic [OUT_TAG_W-1:0] fired_tag_next;

  // memory port
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [TIME_W-1:0]    rd_deadline;
  logic [TAG_WIDTH-1:0] rd_tag;

  // shared adder: now + delay on add, now + 1 on tick, saturating
  logic [DELAY_W-1:0]   addend;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    sum_sat;

  // shared comparator: stored deadline against new deadline or current time
  logic [TIME_W-1:0]    cmp_ref;
  logic                 rd_later;

  logic [TAG_WIDTH+IN_TAG_W-1:0]  tag_in_ext;
  logic [TAG_WIDTH+OUT_TAG_W-1:0] tag_out_ext;
  logic [TAG_WIDTH-1:0]           tag_in;
  logic                           full;

  assign {rd_deadline, rd_tag} = ram_rdata;

  assign addend  = (cmd == CMD_ADD) ? delay_seconds : DELAY_W'(1);
  assign sum     = {1'b0, now_seconds} + {{(TIME_W+1-DELAY_W){1'b0}}, addend};
  assign sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  assign cmp_ref  = (state == ST_ADD_CMP) ? deadline : now_seconds;
  assign rd_later = rd_deadline > cmp_ref;

  // tag width adaptation on the way in and on the way out
  assign tag_in_ext  = {{TAG_WIDTH{1'b0}}, alarm_tag};
  assign tag_in      = tag_in_ext[TAG_WIDTH-1:0];
  assign tag_out_ext = {{OUT_TAG_W{1'b0}}, pend_tag};

  assign full = entry_count == CNT_W'(QUEUE_DEPTH);
  assign busy = state != ST_IDLE;

  always_comb begin
    state_next      = state;
    now_next        = now_seconds;
    deadline_next   = deadline;
    new_tag_next    = new_tag;
    slot_next       = slot;
    head_next       = head;
    count_next      = entry_count;
    num_next        = num_fired;
    pend_valid_next = pend_valid;
    pend_tag_next   = pend_tag;

    valid_next     = 1'b0;
    kind_next      = KIND_ACK;
    status_next    = STATUS_OK;
    last_next      = 1'b1;
    fired_tag_next = '0;

    ram_we    = 1'b0;
    ram_waddr = wrap_add(head, slot);
    ram_wdata = {deadline, new_tag};
    ram_re    = 1'b0;
    ram_raddr = head;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_ADD) begin
            if (full) begin
              // rejected: answer at once, nothing changes
              valid_next  = 1'b1;
              status_next = STATUS_FULL;
            end else begin
              deadline_next = sum_sat;
              new_tag_next  = tag_in;
              slot_next     = entry_count[IDX_W-1:0];
              state_next    = ST_ADD_RD;
            end
          end else begin
            now_next        = sum_sat;
            num_next        = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_TICK_RD;
          end
        end
      end

      ST_ADD_RD: begin
        if (slot == '0) begin
          // reached the head: the new alarm goes first
          ram_we     = 1'b1;
          count_next = entry_count + CNT_W'(1);
          valid_next = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = wrap_add(head, slot - IDX_W'(1));
          state_next = ST_ADD_CMP;
        end
      end

      ST_ADD_CMP: begin
        ram_we = 1'b1;
        if (rd_later) begin
          // later deadline moves up one slot, keep scanning toward the head
          ram_wdata  = ram_rdata;
          slot_next  = slot - IDX_W'(1);
          state_next = ST_ADD_RD;
        end else begin
          // equal or earlier stays ahead of the new alarm
          count_next = entry_count + CNT_W'(1);
          valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_TICK_RD: begin
        if (entry_count == '0 || num_fired == NUM_W'(MAX_RESULTS)) begin
          valid_next     = pend_valid;
          kind_next      = KIND_FIRE;
          fired_tag_next = tag_out_ext[OUT_TAG_W-1:0];
          state_next     = ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_TICK_CMP;
        end
      end

      ST_TICK_CMP: begin
        valid_next     = pend_valid;
        kind_next      = KIND_FIRE;
        fired_tag_next = tag_out_ext[OUT_TAG_W-1:0];
        if (!rd_later) begin
          // head is due: pop it, report the one held before
          last_next       = 1'b0;
          pend_valid_next = 1'b1;
          pend_tag_next   = rd_tag;
          head_next       = wrap_add(head, IDX_W'(1));
          count_next      = entry_count - CNT_W'(1);
          num_next        = num_fired + NUM_W'(1);
          state_next      = ST_TICK_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      now_seconds <= '0;
      entry_count <= '0;
      head        <= '0;
      pend_valid  <= 1'b0;
      valid       <= 1'b0;
    end else begin
      state       <= state_next;
      now_seconds <= now_next;
      entry_count <= count_next;
      head        <= head_next;
      pend_valid  <= pend_valid_next;
      valid       <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    deadline  <= deadline_next;
    new_tag   <= new_tag_next;
    slot      <= slot_next;
    num_fired <= num_next;
    pend_tag  <= pend_tag_next;
    kind      <= kind_next;
    status    <= status_next;
    fired_tag <= fired_tag_next;
    last      <= last_next;
  end

  adq_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/adq_checker.sv
// port-level checks for the alarm deadline queue, bound to the top level
module adq_checker
  import adq_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 valid,
  input logic                 kind,
  input logic                 status,
  input logic [OUT_TAG_W-1:0] fired_tag,
  input logic                 last
);

  // an acknowledgement is the only result of its add and carries no tag
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_ACK |-> last && fired_tag == '0)
    else $error("add acknowledgement without last or with a tag");

  // fired alarms never carry a full status
  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_FIRE |-> status == STATUS_OK)
    else $error("fired alarm with nonzero status");

  // more results of the same tick follow, so the block is still busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result while idle");

  // the final result means the item is done
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("final result while still busy");

  // reset leaves no result and an idle block
  a_reset: assert property (@(posedge clk)
    rst |=> !valid && !busy)
    else $error("result or busy right after reset");

endmodule

bind alarm_deadline_queue adq_checker u_adq_checker (.*);

### bench/tb_alarm_deadline_queue.sv
// testbench for alarm_deadline_queue: table-driven and random commands checked against a predictor
`timescale 1ns / 100ps

module tb_alarm_deadline_queue;
  import adq_pkg::*;

  // one result as it appears on the output ports
  typedef struct packed {
    logic                 kind;
    logic                 status;
    logic [OUT_TAG_W-1:0] tag;
    logic                 last;
  } alarm_result_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    logic                cmd;
    logic [DELAY_W-1:0]  delay;
    logic [IN_TAG_W-1:0] tag;
    logic                typed;
    alarm_result_t       want;
  } stim_row_t;

  localparam alarm_result_t ACK_OK   = '{KIND_ACK, STATUS_OK, 16'd0, 1'b1};
  localparam alarm_result_t ACK_FULL = '{KIND_ACK, STATUS_FULL, 16'd0, 1'b1};
  localparam int QUIET_LIMIT = 4000;   // cycles with no item and no result
  localparam int DRAIN_CYCLES = 40;    // longer than a full shift or pop pass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 cmd = CMD_TICK;
  logic [DELAY_W-1:0]   delay_seconds = '0;
  logic [IN_TAG_W-1:0]  alarm_tag = '0;
  logic                 busy;
  logic                 valid;
  logic                 kind;
  logic                 status;
  logic [OUT_TAG_W-1:0] fired_tag;
  logic                 last;

  // predictor state: seconds counter and the sorted pending alarms
  logic [TIME_W-1:0]    clock_now = '0;
  logic [TIME_W-1:0]    pend_deadline[$];
  logic [OUT_TAG_W-1:0] pend_tag[$];

  alarm_result_t fresh[$];         // results of the item just accepted
  alarm_result_t due_results[$];   // results still to come, oldest first
  alarm_result_t seen_want;

  int errors = 0;
  int items_sent = 0;
  int acks_seen = 0;
  int rejects_seen = 0;
  int fires_seen = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  alarm_deadline_queue uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .delay_seconds (delay_seconds),
    .alarm_tag     (alarm_tag),
    .valid         (valid),
    .kind          (kind),
    .status        (status),
    .fired_tag     (fired_tag),
    .last          (last)
  );

  // work out what one accepted item does to the queue and what it answers
  function automatic void predict(input logic c, input logic [DELAY_W-1:0] d,
                                  input logic [IN_TAG_W-1:0] t);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] when_due;
    int                pos;
    fresh.delete();
    if (c == CMD_ADD) begin
      if (pend_deadline.size() >= QUEUE_DEPTH_DEF) begin
        // queue full: nothing changes
        fresh.push_back(ACK_FULL);
      end else begin
        // deadline saturates at the top of the time range
        sum = {1'b0, clock_now} + {{(TIME_W+1-DELAY_W){1'b0}}, d};
        when_due = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        // equal deadlines keep the order in which they were added
        pos = 0;
        while (pos < pend_deadline.size() && pend_deadline[pos] <= when_due) pos++;
        pend_deadline.insert(pos, when_due);
        pend_tag.insert(pos, t);
        fresh.push_back(ACK_OK);
      end
    end else begin
      // time holds at its maximum
      if (clock_now != '1) clock_now++;
      // pop due alarms, at most one burst's worth per tick
      while (fresh.size() < MAX_RESULTS && pend_deadline.size() > 0 &&
             pend_deadline[0] <= clock_now) begin
        fresh.push_back('{KIND_FIRE, STATUS_OK, pend_tag[0], 1'b0});
        void'(pend_deadline.pop_front());
        void'(pend_tag.pop_front());
      end
      // a quiet tick answers nothing
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    end
  endfunction

  // offer one item after a random gap and hold it until the block takes it
  task automatic issue(input logic c, input logic [DELAY_W-1:0] d,
                       input logic [IN_TAG_W-1:0] t, input int idle_pct,
                       input logic typed, input alarm_result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    delay_seconds <= d;
    alarm_tag <= t;
    do @(posedge clk); while (busy);
    predict(c, d, t);
    if (typed) due_results.push_back(want);
    else foreach (fresh[i]) due_results.push_back(fresh[i]);
    items_sent++;
  endtask

  // let every expected result arrive, then give the block time to settle
  task automatic settle();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker and watchdog, both sampling at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((start && !busy) || valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (valid) begin
        if (kind == KIND_FIRE) fires_seen++;
        else if (status == STATUS_FULL) rejects_seen++;
        else acks_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t result with nothing expected: kind %0d status %0d tag %h last %0d",
                   $time, kind, status, fired_tag, last);
        end else begin
          seen_want = due_results.pop_front();
          if (kind !== seen_want.kind) begin
            errors++;
            $display("%0t kind mismatch: expected %0d actual %0d", $time, seen_want.kind, kind);
          end
          if (status !== seen_want.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, seen_want.status, status);
          end
          if (fired_tag !== seen_want.tag) begin
            errors++;
            $display("%0t fired_tag mismatch: expected %h actual %h",
                     $time, seen_want.tag, fired_tag);
          end
          if (last !== seen_want.last) begin
            errors++;
            $display("%0t last mismatch: expected %0d actual %0d", $time, seen_want.last, last);
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no item or result for %0d cycles", $time, quiet_cycles);
        $display("alarm_deadline_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    int        idle_pct[4];
    int        far_count;
    int        pick;
    logic [DELAY_W-1:0] d;

    idle_pct = '{0, 86, 14, 0};

    // directed table
    // quiet tick straight after reset
    plan.push_back('{CMD_TICK, 16'd0, 16'd0, 1'b0, ACK_OK});
    // extremes of delay and tag, a second alarm on the same deadline
    plan.push_back('{CMD_ADD, 16'd0, 16'hFFFF, 1'b1, ACK_OK});
    plan.push_back('{CMD_ADD, 16'hFFFF, 16'h0000, 1'b1, ACK_OK});
    plan.push_back('{CMD_ADD, 16'd1, 16'h1234, 1'b1, ACK_OK});
    plan.push_back('{CMD_ADD, 16'd0, 16'hA5A5, 1'b1, ACK_OK});
    plan.push_back('{CMD_ADD, 16'd1, 16'h5A5A, 1'b1, ACK_OK});
    // fires the two zero-delay alarms in order, then both one-second ones
    plan.push_back('{CMD_TICK, 16'd0, 16'd0, 1'b0, ACK_OK});
    // fill the queue ahead of the far alarm, then one add too many
    for (int i = 0; i < QUEUE_DEPTH_DEF - 1; i++)
      plan.push_back('{CMD_ADD, 16'd0, 16'h0100 + 16'(i), 1'b1, ACK_OK});
    plan.push_back('{CMD_ADD, 16'd3, 16'hBEEF, 1'b1, ACK_FULL});
    // a burst of fifteen due alarms on one tick
    plan.push_back('{CMD_TICK, 16'd0, 16'd0, 1'b0, ACK_OK});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      issue(plan[i].cmd, plan[i].delay, plan[i].tag, 0, plan[i].typed, plan[i].want);
    settle();

    // random phases, each opening with a burst that overfills the queue
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 17; i++)
        issue(CMD_ADD, DELAY_W'($urandom_range(0, 3)), IN_TAG_W'($urandom),
              idle_pct[ph], 1'b0, ACK_OK);
      for (int i = 0; i < 83; i++) begin
        // alarms far in the future are kept few so the queue keeps moving
        far_count = 0;
        foreach (pend_deadline[k])
          if ({1'b0, pend_deadline[k]} > {1'b0, clock_now} + 33'd16) far_count++;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          issue(CMD_TICK, DELAY_W'($urandom), IN_TAG_W'($urandom),
                idle_pct[ph], 1'b0, ACK_OK);
        end else begin
          if (pick < 85 || far_count >= 4) d = DELAY_W'($urandom_range(0, 6));
          else if (pick < 95) d = DELAY_W'($urandom_range(0, 300));
          else d = DELAY_W'($urandom);
          issue(CMD_ADD, d, IN_TAG_W'($urandom), idle_pct[ph], 1'b0, ACK_OK);
        end
      end
      // hold off until the queue has answered everything so far
      settle();
    end

    $display("covered %0d items: %0d adds taken, %0d rejected as full, %0d alarms fired",
             items_sent, acks_seen, rejects_seen, fires_seen);
    $display("sender gaps of 0, 86 and 14 in 100 cycles; %0d checks failed", errors);
    if (errors == 0)
      $display("alarm_deadline_queue regression: pass");
    else
      $display("alarm_deadline_queue regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/adq_pkg.sv
rtl/adq_entry_ram.sv
rtl/alarm_deadline_queue.sv
rtl/adq_checker.sv
bench/tb_alarm_deadline_queue.sv
